/* design/dns_query_name_extractor_unit_macros.svh */
// assertion macros for the dns query name extractor checker
// expects clk and rst in the scope where the macros are used
`ifndef DNS_QUERY_NAME_EXTRACTOR_UNIT_MACROS_SVH
`define DNS_QUERY_NAME_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQNE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqne assertion failed");

// next-cycle implication, disabled during reset
`define DQNE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqne assertion failed");

`endif

/* design/dqne_pkg.sv */
// shared constants and types for the dns query name extractor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dqne_pkg;

  // scan window and name buffer sizes
  localparam int SCAN_BYTES  = 128;
  localparam int NAME_BYTES  = 128;
  localparam int NAME_OFFSET = 12;

  localparam int POS_W  = $clog2(SCAN_BYTES + 1);
  localparam int CHAR_W = $clog2(NAME_BYTES);

  // header byte offsets
  localparam logic [POS_W-1:0] POS_FLAGS    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_COUNT_HI = POS_W'(4);
  localparam logic [POS_W-1:0] POS_COUNT_LO = POS_W'(5);
  localparam logic [POS_W-1:0] POS_NAME     = POS_W'(NAME_OFFSET);
  localparam logic [POS_W-1:0] POS_SCAN_END = POS_W'(SCAN_BYTES);
  localparam logic [POS_W-1:0] POS_SCAN_LAST = POS_W'(SCAN_BYTES - 1);

  localparam logic [CHAR_W-1:0] CHAR_LAST = CHAR_W'(NAME_BYTES - 1);

  // address families
  localparam logic [15:0] FAMILY_V4 = 16'd2;
  localparam logic [15:0] FAMILY_V6 = 16'd10;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DNS_PORT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAYLOAD = 2'd2;

  localparam logic [15:0] DNS_PORT_RESET    = 16'd53;
  localparam logic [3:0]  LABEL_LIMIT_RESET = 4'd10;
  localparam logic [7:0]  MIN_PAYLOAD_RESET = 8'd13;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // one queued transaction: an optional character and an optional terminator
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       has_end;
  } dqne_entry_t;

endpackage

`default_nettype wire

/* design/dqne_front.sv */
// front end: packet filter, header checks and label parser
// depends on dqne_pkg
`timescale 1ns / 1ps
`default_nettype none

module dqne_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [dqne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          accept,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          first_byte,
  input  wire logic                          last_byte,
  input  wire logic                          has_destination,
  input  wire logic [15:0]                   address_family,
  input  wire logic [15:0]                   destination_port,
  input  wire logic [15:0]                   payload_length,
  output logic                               enq,
  output dqne_pkg::dqne_entry_t              enq_entry
);
  import dqne_pkg::*;

  logic [15:0] dns_port;
  logic [3:0]  label_limit;
  logic [7:0]  min_payload;

  logic              packet_accepted, packet_accepted_next;
  logic              parse_finished, parse_finished_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        count_high_byte, count_high_byte_next;
  logic [3:0]        label_count, label_count_next;
  logic [5:0]        label_remaining, label_remaining_next;
  logic [CHAR_W-1:0] chars_written, chars_written_next;

  logic             acc0;
  logic [POS_W-1:0] p;
  logic             want_char;
  logic [7:0]       char_val;
  logic             do_char;
  logic             do_end;
  logic             at_end;

  // per-byte parse step
  always_comb begin
    acc0 = first_byte ?
           (has_destination &&
            (address_family == FAMILY_V4 || address_family == FAMILY_V6) &&
            destination_port == dns_port &&
            payload_length >= {8'd0, min_payload}) : packet_accepted;
    packet_accepted_next = acc0;
    parse_finished_next  = first_byte ? 1'b0 : parse_finished;
    byte_position_next   = first_byte ? '0 : byte_position;
    count_high_byte_next = first_byte ? 8'd0 : count_high_byte;
    label_count_next     = first_byte ? 4'd0 : label_count;
    label_remaining_next = first_byte ? 6'd0 : label_remaining;
    chars_written_next   = first_byte ? '0 : chars_written;
    p         = byte_position_next;
    at_end    = (p == POS_SCAN_LAST);
    want_char = 1'b0;
    char_val  = data_byte;
    do_char   = 1'b0;
    do_end    = 1'b0;

    if (!acc0 || parse_finished_next) begin
      if (last_byte) packet_accepted_next = 1'b0;
    end else if ((p == POS_FLAGS && data_byte[7]) ||
                 (p == POS_COUNT_LO && count_high_byte_next == 8'd0 &&
                  data_byte == 8'd0)) begin
      // response bit set or no questions
      packet_accepted_next = 1'b0;
    end else begin
      if (p == POS_COUNT_HI) count_high_byte_next = data_byte;

      // name region
      if (p >= POS_NAME && p < POS_SCAN_END) begin
        if (label_remaining_next == 6'd0) begin
          if (label_count_next >= label_limit || data_byte == 8'd0 ||
              data_byte[7:6] != 2'b00) begin
            do_end = 1'b1;
          end else begin
            label_count_next     = label_count_next + 4'd1;
            label_remaining_next = data_byte[5:0];
            if (chars_written_next != '0) begin
              want_char = 1'b1;
              char_val  = DOT_CHAR;
            end
            if (at_end) do_end = 1'b1;
          end
        end else begin
          want_char            = 1'b1;
          label_remaining_next = label_remaining_next - 6'd1;
          if (at_end || (label_remaining_next == 6'd0 &&
                         label_count_next >= label_limit))
            do_end = 1'b1;
        end
      end

      // characters past the name buffer are dropped
      if (want_char && chars_written_next < CHAR_LAST) begin
        do_char            = 1'b1;
        chars_written_next = chars_written_next + 1'b1;
      end

      if (byte_position_next < POS_SCAN_END)
        byte_position_next = byte_position_next + 1'b1;

      // short packet: remainder counts as zero padding
      if (last_byte) begin
        if (!do_end && (p >= POS_COUNT_LO ||
                        (p == POS_COUNT_HI && count_high_byte_next != 8'd0)))
          do_end = 1'b1;
        packet_accepted_next = 1'b0;
      end

      if (do_end) begin
        parse_finished_next  = 1'b1;
        packet_accepted_next = 1'b0;
      end
    end
  end

  assign enq = accept && (do_char || do_end);
  assign enq_entry = '{ch: char_val, has_char: do_char, has_end: do_end};

  // parser state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port        <= DNS_PORT_RESET;
      label_limit     <= LABEL_LIMIT_RESET;
      min_payload     <= MIN_PAYLOAD_RESET;
      packet_accepted <= 1'b0;
      parse_finished  <= 1'b0;
      byte_position   <= '0;
      count_high_byte <= 8'd0;
      label_count     <= 4'd0;
      label_remaining <= 6'd0;
      chars_written   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DNS_PORT:    dns_port    <= cfg_data;
          REG_LABEL_LIMIT: label_limit <= cfg_data[3:0];
          REG_MIN_PAYLOAD: min_payload <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        packet_accepted <= packet_accepted_next;
        parse_finished  <= parse_finished_next;
        byte_position   <= byte_position_next;
        count_high_byte <= count_high_byte_next;
        label_count     <= label_count_next;
        label_remaining <= label_remaining_next;
        chars_written   <= chars_written_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/dqne_queue.sv */
// short queue of parsed transactions between front and back
// depends on dqne_pkg
`timescale 1ns / 1ps
`default_nettype none

module dqne_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  enq,
  input  wire dqne_pkg::dqne_entry_t enq_entry,
  input  wire logic                  deq,
  output dqne_pkg::dqne_entry_t      head,
  output logic                       empty,
  output logic                       full
);
  import dqne_pkg::*;

  dqne_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_enq, do_deq;

  assign empty  = (count == '0);
  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;
  assign head   = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_enq) slots[wr_ptr] <= enq_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) wr_ptr <= wr_ptr + 1'b1;
      if (do_deq) rd_ptr <= rd_ptr + 1'b1;
      case ({do_enq, do_deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dqne_back.sv */
// back end: expands each queued transaction into one or two results
// depends on dqne_pkg
`timescale 1ns / 1ps
`default_nettype none

module dqne_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dqne_pkg::dqne_entry_t head,
  input  wire logic                  q_empty,
  input  wire logic                  pop,
  output logic                       deq,
  output logic [7:0]                 name_char,
  output logic                       end_of_name
);
  import dqne_pkg::*;

  // set once the character of a two-result entry has been taken
  logic second;
  logic show_char;
  logic take;

  assign show_char   = head.has_char && !second;
  assign name_char   = show_char ? head.ch : 8'd0;
  assign end_of_name = !show_char;
  assign take        = pop && !q_empty;
  assign deq         = take && !(show_char && head.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= show_char && head.has_end;
    end
  end

endmodule

`default_nettype wire

/* design/dns_query_name_extractor_unit.sv */
// dns query name extractor: one payload byte per cycle while the queue is not full, no stall from parsing
// a result is registered in the transaction queue before it reaches the output; a byte that
// yields a character and the terminator drains as the character followed by the terminator
// throughput is set by the four-entry transaction queue and the single pop
// reset (synchronous, active high) empties the queue, clears the parser
// and restores dns_port 53, label_limit 10, min_payload 13
`timescale 1ns / 1ps
`default_nettype none

module dns_query_name_extractor_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [dqne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          first_byte,
  input  wire logic                          last_byte,
  input  wire logic                          has_destination,
  input  wire logic [15:0]                   address_family,
  input  wire logic [15:0]                   destination_port,
  input  wire logic [15:0]                   payload_length,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         name_char,
  output logic                               end_of_name
);
  import dqne_pkg::*;

  logic        enq, deq, q_full, q_empty;
  dqne_entry_t enq_entry, head;

  assign full  = q_full;
  assign empty = q_empty;

  // parser front end
  dqne_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accept           (push && !q_full),
    .data_byte        (data_byte),
    .first_byte       (first_byte),
    .last_byte        (last_byte),
    .has_destination  (has_destination),
    .address_family   (address_family),
    .destination_port (destination_port),
    .payload_length   (payload_length),
    .enq              (enq),
    .enq_entry        (enq_entry)
  );

  // transaction queue
  dqne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_entry (enq_entry),
    .deq       (deq),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // result back end
  dqne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .deq         (deq),
    .name_char   (name_char),
    .end_of_name (end_of_name)
  );

endmodule

`default_nettype wire

/* design/dqne_checker.sv */
// port-level checker for the dns query name extractor, bound to the top level
// depends on dns_query_name_extractor_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "dns_query_name_extractor_unit_macros.svh"

module dqne_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] name_char,
  input wire logic       end_of_name
);

  // terminator always carries a zero character
  `DQNE_ASSERT_NOW(a_term_zero, !empty && end_of_name, name_char == 8'd0)

  // nothing appears at the output without an accepted byte
  `DQNE_ASSERT_NEXT(a_no_spurious, empty && !(push && !full), empty)

  // a waiting result holds until taken
  `DQNE_ASSERT_NEXT(a_hold, !empty && !pop,
    !empty && $stable(name_char) && $stable(end_of_name))

  // a full queue stays full until a result is taken
  `DQNE_ASSERT_NEXT(a_full_hold, full && !(pop && !empty), full)

endmodule

bind dns_query_name_extractor_unit dqne_checker u_dqne_checker (.*);

`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench for dns_query_name_extractor_unit
// drives payload bytes and register writes, predicts the query name in-line
// depends on dqne_pkg and the unit itself
`timescale 1ns / 1ps

module tb_top;
  import dqne_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int LIMIT_CYCLES    = 500_000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int N_PHASES        = 6;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_AFTER      = 150;
  localparam int HOLD_CYCLES     = 500;
  localparam int LABEL_MAX       = 63;
  localparam int SIDE_SEND       = 0;
  localparam int SIDE_RECV       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one name result: a character or the terminator
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } name_item_t;

  // one payload byte with its packet facts and an optional hand-typed result
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        has_dst;
    logic [15:0] fam;
    logic [15:0] port;
    logic [15:0] plen;
    int          typed_n;
    name_item_t  typed_item;
  } byte_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 push;
  logic                 full;
  logic [7:0]           data_byte;
  logic                 first_byte;
  logic                 last_byte;
  logic                 has_destination;
  logic [15:0]          address_family;
  logic [15:0]          destination_port;
  logic [15:0]          payload_length;
  logic                 empty;
  logic                 pop;
  logic [7:0]           name_char;
  logic                 end_of_name;

  // hand-typed expectation that travels with the byte on the bus
  int                   typed_n_drv;
  name_item_t           typed_item_drv;

  dns_query_name_extractor_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .data_byte        (data_byte),
    .first_byte       (first_byte),
    .last_byte        (last_byte),
    .has_destination  (has_destination),
    .address_family   (address_family),
    .destination_port (destination_port),
    .payload_length   (payload_length),
    .empty            (empty),
    .pop              (pop),
    .name_char        (name_char),
    .end_of_name      (end_of_name)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // ---------------------------------------------------------------------------
  // name predictor: own copy of registers and parser state
  // ---------------------------------------------------------------------------
  logic [15:0] port_cfg;
  logic [3:0]  limit_cfg;
  logic [7:0]  min_len_cfg;

  logic [7:0]  scan_pos;
  logic        in_query;
  logic [7:0]  qd_high;
  logic [3:0]  labels_taken;
  logic [5:0]  label_left;
  logic [6:0]  name_len;
  logic        name_closed;

  name_item_t  step_items [2];
  int          step_count;

  name_item_t  pending_names [$];
  int          mismatches;
  int          random_items;
  int          calm_left [2];
  byte_row_t   directed_rows [$];

  function automatic void name_emit(logic [7:0] c, logic e);
    step_items[step_count] = '{ch: c, is_end: e};
    step_count++;
  endfunction

  // characters beyond the buffer are dropped without a result
  function automatic void name_put_char(logic [7:0] c);
    if (int'(name_len) < NAME_BYTES - 1) begin
      name_emit(c, 1'b0);
      name_len++;
    end
  endfunction

  function automatic void name_close();
    name_emit(8'h00, 1'b1);
    name_closed = 1'b1;
    in_query    = 1'b0;
  endfunction

  function automatic void predictor_reset();
    port_cfg     = DNS_PORT_RESET;
    limit_cfg    = LABEL_LIMIT_RESET;
    min_len_cfg  = MIN_PAYLOAD_RESET;
    scan_pos     = '0;
    in_query     = 1'b0;
    qd_high      = '0;
    labels_taken = '0;
    label_left   = '0;
    name_len     = '0;
    name_closed  = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    case (idx)
      REG_DNS_PORT:    port_cfg = v;
      REG_LABEL_LIMIT: limit_cfg = v[3:0];
      REG_MIN_PAYLOAD: min_len_cfg = v[7:0];
      default: ;
    endcase
  endfunction

  // one payload byte in, up to two name results out in step_items
  function automatic void parse_payload_byte(logic [7:0] d, logic first, logic last,
                                             logic hd, logic [15:0] fam,
                                             logic [15:0] port, logic [15:0] plen);
    int   pos;
    logic at_end;
    step_count = 0;
    // a new packet restarts the parser and decides acceptance
    if (first) begin
      scan_pos     = '0;
      qd_high      = '0;
      labels_taken = '0;
      label_left   = '0;
      name_len     = '0;
      name_closed  = 1'b0;
      in_query     = hd && (fam == FAMILY_V4 || fam == FAMILY_V6) && port == port_cfg &&
                     plen >= {8'h00, min_len_cfg};
    end
    if (!in_query || name_closed) begin
      if (last) in_query = 1'b0;
      return;
    end
    pos = int'(scan_pos);
    // response bit set or zero question count drops the packet
    if ((pos == int'(POS_FLAGS) && d[7]) ||
        (pos == int'(POS_COUNT_LO) && qd_high == 8'h00 && d == 8'h00)) begin
      in_query = 1'b0;
      return;
    end
    if (pos == int'(POS_COUNT_HI)) qd_high = d;
    // label walk inside the scan window
    if (pos >= NAME_OFFSET && pos < SCAN_BYTES) begin
      at_end = (pos + 1) >= SCAN_BYTES;
      if (label_left == 0) begin
        if (labels_taken >= limit_cfg || d == 8'h00 || int'(d) > LABEL_MAX) begin
          name_close();
        end else begin
          labels_taken++;
          label_left = d[5:0];
          if (name_len != 0) name_put_char(DOT_CHAR);
          if (at_end) name_close();
        end
      end else begin
        name_put_char(d);
        label_left--;
        if (at_end || (label_left == 0 && labels_taken >= limit_cfg)) name_close();
      end
    end
    if (int'(scan_pos) < SCAN_BYTES) scan_pos++;
    // a short packet reads as zero padded
    if (last) begin
      if (in_query && !name_closed &&
          (pos >= int'(POS_COUNT_LO) || (pos == int'(POS_COUNT_HI) && qd_high != 8'h00)))
        name_close();
      in_query = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: predict on each input transaction, check each output one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    name_item_t want;
    if (rst) begin
      predictor_reset();
    end else begin
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (push && !full) begin
        parse_payload_byte(data_byte, first_byte, last_byte, has_destination,
                           address_family, destination_port, payload_length);
        if (typed_n_drv < 0) begin
          for (int i = 0; i < step_count; i++) pending_names.push_back(step_items[i]);
        end else begin
          for (int i = 0; i < typed_n_drv; i++) pending_names.push_back(typed_item_drv);
        end
      end
      if (pop && !empty) begin
        if (pending_names.size() == 0) begin
          $error("unexpected result: name_char 0x%02h end_of_name %0b",
                 name_char, end_of_name);
          mismatches++;
        end else begin
          want = pending_names.pop_front();
          if (name_char !== want.ch) begin
            $error("name_char: expected 0x%02h, actual 0x%02h", want.ch, name_char);
            mismatches++;
          end
          if (end_of_name !== want.is_end) begin
            $error("end_of_name: expected %0b, actual %0b", want.is_end, end_of_name);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // idle draw per transaction, with runs of back-to-back transactions
  function automatic int pick_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void add_row(logic [7:0] d, logic f, logic l, logic hd,
                                  logic [15:0] fam, logic [15:0] port, logic [15:0] plen,
                                  int n, logic [7:0] c, logic e);
    byte_row_t r;
    r.data       = d;
    r.first      = f;
    r.last       = l;
    r.has_dst    = hd;
    r.fam        = fam;
    r.port       = port;
    r.plen       = plen;
    r.typed_n    = n;
    r.typed_item = '{ch: c, is_end: e};
    directed_rows.push_back(r);
  endfunction

  task automatic send_row(byte_row_t r);
    int gap;
    gap = pick_gap(SIDE_SEND);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push             <= 1'b1;
    data_byte        <= r.data;
    first_byte       <= r.first;
    last_byte        <= r.last;
    has_destination  <= r.has_dst;
    address_family   <= r.fam;
    destination_port <= r.port;
    payload_length   <= r.plen;
    typed_n_drv      <= r.typed_n;
    typed_item_drv   <= r.typed_item;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  // wait for every expected result, then let the pipeline drain
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_names.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one random packet: mostly well-formed queries, some noise and stray bytes
  task automatic random_packet();
    logic [7:0]  pkt [$];
    byte_row_t   row;
    int          kind;
    int          n_lab;
    int          len;
    int          cut_at;
    bit          long_names;
    bit          drop_last;
    bit          in_pkt;
    logic        hd;
    logic [15:0] fam;
    logic [15:0] port;
    logic [15:0] plen;
    kind      = $urandom_range(0, 99);
    in_pkt    = 1'b1;
    drop_last = 1'b0;
    hd        = 1'b1;
    fam       = $urandom_range(0, 1) ? FAMILY_V4 : FAMILY_V6;
    port      = port_cfg;
    plen      = 16'($urandom_range(int'(min_len_cfg), 65535));
    if (kind < 8) begin
      // stray bytes with no first byte flag
      in_pkt = 1'b0;
      repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
    end else if (kind < 22) begin
      // noise packet with loose destination facts
      hd = 1'($urandom);
      if ($urandom_range(0, 2) == 0) fam = 16'($urandom);
      if ($urandom_range(0, 2) == 0) port = 16'($urandom);
      plen = 16'($urandom);
      repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
      drop_last = $urandom_range(0, 4) == 0;
    end else begin
      // occasionally break one acceptance fact
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: hd = 1'b0;
          1: fam = 16'($urandom);
          2: port = port_cfg + 16'($urandom_range(1, 65535));
          default: begin
            if (min_len_cfg != 8'h00) plen = 16'($urandom_range(0, int'(min_len_cfg) - 1));
            else hd = 1'b0;
          end
        endcase
      end else if ($urandom_range(0, 7) == 0) begin
        plen = {8'h00, min_len_cfg};
      end
      // header: id, flags with qr mostly clear, qdcount mostly nonzero
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back({($urandom_range(0, 11) == 0), 7'($urandom)});
      pkt.push_back(8'($urandom));
      pkt.push_back($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'h00);
      pkt.push_back((pkt[4] != 8'h00 || $urandom_range(0, 9) == 0) ?
                    8'($urandom) : 8'($urandom_range(1, 255)));
      repeat (6) pkt.push_back(8'($urandom));
      // labels, some long enough to run into the end of the scan window
      long_names = $urandom_range(0, 9) == 0;
      if (long_names) n_lab = $urandom_range(2, 4);
      else if ($urandom_range(0, 3) == 0) n_lab = $urandom_range(1, 16);
      else n_lab = $urandom_range(1, 4);
      for (int k = 0; k < n_lab; k++) begin
        if (long_names) len = $urandom_range(40, LABEL_MAX);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(11, LABEL_MAX);
        else len = $urandom_range(1, 10);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
      end
      // end of name: root, compression pointer, oversized length or nothing
      case ($urandom_range(0, 9))
        0: pkt.push_back(8'($urandom_range(192, 255)));
        1: pkt.push_back(8'($urandom_range(LABEL_MAX + 1, 191)));
        2: ;
        default: pkt.push_back(8'h00);
      endcase
      repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
      // short packets, and packets left open for the next one to abandon
      if ($urandom_range(0, 7) == 0) begin
        cut_at = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(1, pkt.size());
        while (pkt.size() > cut_at) void'(pkt.pop_back());
      end
      drop_last = $urandom_range(0, 11) == 0;
    end
    // facts are only meaningful on the first byte; the rest carry junk
    for (int i = 0; i < pkt.size(); i++) begin
      row.data       = pkt[i];
      row.first      = in_pkt && i == 0;
      row.last       = in_pkt ? (i == pkt.size() - 1 && !drop_last) : 1'($urandom);
      row.has_dst    = row.first ? hd : 1'($urandom);
      row.fam        = row.first ? fam : 16'($urandom);
      row.port       = row.first ? port : 16'($urandom);
      row.plen       = row.first ? plen : 16'($urandom);
      row.typed_n    = -1;
      row.typed_item = '0;
      send_row(row);
    end
    if (in_pkt) random_items += pkt.size();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random pop idling plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int gap;
    int taken;
    pop   = 1'b0;
    taken = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = pick_gap(SIDE_RECV);
      if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // input side: directed table, then random phases under several settings
  // ---------------------------------------------------------------------------
  initial begin : payload_side
    int          ph;
    logic [15:0] port_val;
    logic [3:0]  limit_val;
    logic [7:0]  min_val;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    push             = 1'b0;
    data_byte        = '0;
    first_byte       = 1'b0;
    last_byte        = 1'b0;
    has_destination  = 1'b0;
    address_family   = '0;
    destination_port = '0;
    payload_length   = '0;
    typed_n_drv      = -1;
    typed_item_drv   = '0;
    mismatches       = 0;
    random_items     = 0;

    // stray byte before any packet, every field but first_byte at its top value
    add_row(8'hff, 1'b1 ^ 1'b1, 1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff, 0, 8'h00, 1'b0);
    // ipv6 query at the minimum length: one label holding 0xff, then the root
    add_row(8'h00, 1'b1, 1'b0, 1'b1, FAMILY_V6, DNS_PORT_RESET, 16'(MIN_PAYLOAD_RESET),
            0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    repeat (6) add_row(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1, 8'hff, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1, 8'h00, 1'b1);
    // ipv4 packet dropped on the response bit
    add_row(8'h00, 1'b1, 1'b0, 1'b1, FAMILY_V4, DNS_PORT_RESET, 16'hffff, 0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    // short packet ending on a nonzero qdcount high byte: terminator at once
    add_row(8'h00, 1'b1, 1'b0, 1'b1, FAMILY_V4, DNS_PORT_RESET, 16'd13, 0, 8'h00, 1'b0);
    repeat (3) add_row(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1, 8'h00, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    for (ph = 0; ph < N_PHASES; ph++) begin
      // register settings change only with the unit idle
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin port_val = 16'h0000; limit_val = 4'd15; min_val = 8'd0; end
          2: begin port_val = 16'hffff; limit_val = 4'd1; min_val = 8'd255; end
          3: begin port_val = DNS_PORT_RESET; limit_val = 4'd0; min_val = MIN_PAYLOAD_RESET; end
          4: begin
            port_val  = 16'($urandom);
            limit_val = 4'($urandom_range(1, 15));
            min_val   = 8'($urandom);
          end
          default: begin
            port_val  = DNS_PORT_RESET;
            limit_val = LABEL_LIMIT_RESET;
            min_val   = MIN_PAYLOAD_RESET;
          end
        endcase
        // unused upper data bits carry junk
        write_reg(REG_DNS_PORT, port_val);
        write_reg(REG_LABEL_LIMIT, {12'($urandom), limit_val});
        write_reg(REG_MIN_PAYLOAD, {8'($urandom), min_val});
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_write <= 1'b0;
      end
      while (random_items < (ph + 1) * ITEMS_PER_PHASE) random_packet();
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
